/* src/pcsc_pkg.sv */
package pcsc_pkg;

	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;
	localparam int ACC_W     = 26;
	localparam int Q_SHIFT   = 14;

	typedef enum logic [1:0] {
		MODE_TO_YCC      = 2'd0,
		MODE_TO_BGR      = 2'd1,
		MODE_BRIGHT_ALL  = 2'd2,
		MODE_BRIGHT_LUMA = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_CHROMA_OFFSET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_OFFSET = 2'd1;

	localparam logic [7:0] CHROMA_OFFSET_RST     = 8'd128;
	localparam logic [8:0] BRIGHTNESS_OFFSET_RST = 9'd0;

	// Q14 coefficients
	localparam logic signed [15:0] K_Y_R  = 16'sd4899;
	localparam logic signed [15:0] K_Y_G  = 16'sd9617;
	localparam logic signed [15:0] K_Y_B  = 16'sd1868;
	localparam logic signed [15:0] K_CR   = 16'sd11682;
	localparam logic signed [15:0] K_CB   = 16'sd9241;
	localparam logic signed [15:0] K_R_CR = 16'sd22987;
	localparam logic signed [15:0] K_G_CR = 16'sd11698;
	localparam logic signed [15:0] K_G_CB = 16'sd5636;
	localparam logic signed [15:0] K_B_CB = 16'sd29049;

	localparam logic signed [ACC_W-1:0] Q_HALF = 26'sd8192;

	typedef struct packed {
		mode_t             mode;
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_a;
		logic [CHAN_W-1:0] out_b;
		logic [CHAN_W-1:0] out_c;
	} pix_out_t;

	typedef struct packed {
		logic [7:0]        chroma_offset;
		logic signed [8:0] brightness_offset;
	} pcsc_cfg_t;

	// clamp a Q14 sum to 0..255 after the shift
	function automatic logic [CHAN_W-1:0] sat_q(input logic signed [ACC_W-1:0] t);
		logic [CHAN_W-1:0] r;
		if (t[ACC_W-1]) begin
			r = '0;
		end else if (|t[ACC_W-2:Q_SHIFT+CHAN_W]) begin
			r = '1;
		end else begin
			r = t[Q_SHIFT+CHAN_W-1:Q_SHIFT];
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] sat_int(input logic signed [9:0] v);
		logic [CHAN_W-1:0] r;
		if (v[9]) begin
			r = '0;
		end else if (v[8]) begin
			r = '1;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] add_bright(input logic [CHAN_W-1:0] x,
			input logic signed [8:0] k);
		logic signed [9:0] s;
		s = $signed({2'b00, x}) + $signed({k[8], k});
		return sat_int(s);
	endfunction

endpackage

/* src/pcsc_datapath.sv */
module pcsc_datapath
	import pcsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pcsc_cfg_t cfg,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  pix_in_t   pix,
	output logic      res_valid,
	input  logic      res_ready,
	output pix_out_t  res
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || res_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_ready = en1;
	assign res_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: luma product sum, chroma deltas, brightness
	mode_t                   mode_s1;
	logic [CHAN_W-1:0]       a_s1, c_s1;
	logic signed [ACC_W-1:0] ysum_s1;
	logic signed [8:0]       dcr_s1, dcb_s1;
	pix_out_t                bri_s1;

	logic signed [ACC_W-1:0] ysum;
	logic signed [8:0]       dcr, dcb;
	pix_out_t                bri;

	always_comb begin
		ysum = ACC_W'(K_Y_R) * $signed({18'b0, pix.chan_c})
			+ ACC_W'(K_Y_G) * $signed({18'b0, pix.chan_b})
			+ ACC_W'(K_Y_B) * $signed({18'b0, pix.chan_a})
			+ Q_HALF;
		dcr = $signed({1'b0, pix.chan_b}) - $signed({1'b0, cfg.chroma_offset});
		dcb = $signed({1'b0, pix.chan_c}) - $signed({1'b0, cfg.chroma_offset});
		bri.out_a = add_bright(pix.chan_a, cfg.brightness_offset);
		if (pix.mode == MODE_BRIGHT_LUMA) begin
			bri.out_b = pix.chan_b;
			bri.out_c = pix.chan_c;
		end else begin
			bri.out_b = add_bright(pix.chan_b, cfg.brightness_offset);
			bri.out_c = add_bright(pix.chan_c, cfg.brightness_offset);
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pix_valid) begin
			mode_s1 <= pix.mode;
			a_s1    <= pix.chan_a;
			c_s1    <= pix.chan_c;
			ysum_s1 <= ysum;
			dcr_s1  <= dcr;
			dcb_s1  <= dcb;
			bri_s1  <= bri;
		end
	end

	// stage 2: saturated luma and differences; inverse products
	mode_t                   mode_s2;
	logic [CHAN_W-1:0]       a_s2, y_s2;
	logic signed [8:0]       dr_s2, db_s2;
	logic signed [ACC_W-1:0] pr_s2, pgcr_s2, pgcb_s2, pb_s2;
	pix_out_t                bri_s2;

	logic [CHAN_W-1:0] y;

	assign y = sat_q(ysum_s1);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			mode_s2 <= mode_s1;
			a_s2    <= a_s1;
			y_s2    <= y;
			dr_s2   <= $signed({1'b0, c_s1}) - $signed({1'b0, y});
			db_s2   <= $signed({1'b0, a_s1}) - $signed({1'b0, y});
			pr_s2   <= ACC_W'(K_R_CR) * ACC_W'(dcr_s1);
			pgcr_s2 <= ACC_W'(K_G_CR) * ACC_W'(dcr_s1);
			pgcb_s2 <= ACC_W'(K_G_CB) * ACC_W'(dcb_s1);
			pb_s2   <= ACC_W'(K_B_CB) * ACC_W'(dcb_s1);
			bri_s2  <= bri_s1;
		end
	end

	// stage 3: chroma products or inverse sums, shared accumulators
	mode_t                   mode_s3;
	logic [CHAN_W-1:0]       y_s3;
	logic signed [ACC_W-1:0] acc_a_s3, acc_b_s3, acc_c_s3;
	pix_out_t                bri_s3;

	logic signed [ACC_W-1:0] yq;
	logic signed [ACC_W-1:0] acc_a, acc_b, acc_c;

	always_comb begin
		yq = $signed({4'b0, a_s2, 14'b0});
		if (mode_s2 == MODE_TO_YCC) begin
			acc_a = '0;
			acc_b = ACC_W'(K_CR) * ACC_W'(dr_s2);
			acc_c = ACC_W'(K_CB) * ACC_W'(db_s2);
		end else begin
			acc_a = yq + pb_s2 + Q_HALF;
			acc_b = yq - pgcr_s2 - pgcb_s2 + Q_HALF;
			acc_c = yq + pr_s2 + Q_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			mode_s3  <= mode_s2;
			y_s3     <= y_s2;
			acc_a_s3 <= acc_a;
			acc_b_s3 <= acc_b;
			acc_c_s3 <= acc_c;
			bri_s3   <= bri_s2;
		end
	end

	// stage 4: offset, saturation, mode select
	logic signed [ACC_W-1:0] offq;
	pix_out_t                res_d;

	always_comb begin
		offq = $signed({4'b0, cfg.chroma_offset, 14'b0}) + Q_HALF;
		unique case (mode_s3)
			MODE_TO_YCC: begin
				res_d.out_a = y_s3;
				res_d.out_b = sat_q(acc_b_s3 + offq);
				res_d.out_c = sat_q(acc_c_s3 + offq);
			end
			MODE_TO_BGR: begin
				res_d.out_a = sat_q(acc_a_s3);
				res_d.out_b = sat_q(acc_b_s3);
				res_d.out_c = sat_q(acc_c_s3);
			end
			MODE_BRIGHT_ALL, MODE_BRIGHT_LUMA: begin
				res_d = bri_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			res <= res_d;
		end
	end

endmodule

/* src/pixel_color_space_converter.sv */
// BT.601 pixel color converter: BGR to YCrCb, YCrCb to BGR, and two brightness
// modes, all saturated to 0..255. One pixel per clock when the result side
// keeps up; a request reaches its result through four register stages (luma
// sum, deltas and products, chroma products, offset and clamp). Each stage
// stalls on its own, so a request is taken while a result waits as long as
// an earlier stage is free. Registers: index 0 chroma offset (reset 128),
// index 1 signed brightness offset (reset 0); write them only while no
// request is in flight. Other indexes are ignored.
module pixel_color_space_converter
	import pcsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_in_t              pix,
	output logic                 res_valid,
	input  logic                 res_ready,
	output pix_out_t             res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	pcsc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chroma_offset     <= CHROMA_OFFSET_RST;
			cfg_q.brightness_offset <= BRIGHTNESS_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHROMA_OFFSET:     cfg_q.chroma_offset <= cfg_data[7:0];
				REG_BRIGHTNESS_OFFSET: cfg_q.brightness_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	pcsc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

/* src/pcsc_checker.sv */
module pcsc_checker
	import pcsc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     pix_valid,
	input logic     pix_ready,
	input pix_in_t  pix,
	input logic     res_valid,
	input logic     res_ready,
	input pix_out_t res
);

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("request changed while waiting");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// no backpressure at the input while the output drains
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> pix_ready)
		else $error("request stalled with output ready");

	// a request reaches the result through the four stages without stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && res_ready) ##1 res_ready ##1 res_ready
			|-> ##2 res_valid)
		else $error("result missing after pipeline latency");

endmodule

bind pixel_color_space_converter pcsc_checker u_pcsc_checker (.*);

/* bench/pixel_result_checker.sv */
`timescale 1ns / 100ps

module pixel_result_checker
	import pcsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_ready,
	input  pix_in_t              pix,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  pix_out_t             res,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam int ROUND_HALF = 8192;
	localparam int Q_ONE      = 16384;
	localparam int C_Y_R      = 4899;
	localparam int C_Y_G      = 9617;
	localparam int C_Y_B      = 1868;
	localparam int C_CR       = 11682;
	localparam int C_CB       = 9241;
	localparam int C_R_CR     = 22987;
	localparam int C_G_CR     = 11698;
	localparam int C_G_CB     = 5636;
	localparam int C_B_CB     = 29049;

	pix_out_t          expected_pix[$];
	logic [7:0]        chroma_zero;
	logic signed [8:0] bright;
	int                mismatch_count = 0;
	int                queued = 0;

	assign errors  = mismatch_count;
	assign pending = queued;

	function automatic logic [7:0] clamp8(input int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic logic [7:0] clamp_q14(input int t);
		if (t < 0) begin
			return 8'd0;
		end
		return clamp8(t >>> 14);
	endfunction

	function automatic pix_out_t convert_pixel(input pix_in_t p, input logic [7:0] zero,
			input logic signed [8:0] kb);
		int a, b, c, z, zq, k, y, yq, dcr, dcb;
		pix_out_t r;
		a  = p.chan_a;
		b  = p.chan_b;
		c  = p.chan_c;
		z  = zero;
		zq = z * Q_ONE;
		k  = kb;
		case (p.mode)
			MODE_TO_YCC: begin
				y       = clamp_q14(C_Y_R * c + C_Y_G * b + C_Y_B * a + ROUND_HALF);
				r.out_a = y[7:0];
				r.out_b = clamp_q14(C_CR * (c - y) + zq + ROUND_HALF);
				r.out_c = clamp_q14(C_CB * (a - y) + zq + ROUND_HALF);
			end
			MODE_TO_BGR: begin
				yq      = a * Q_ONE;
				dcr     = b - z;
				dcb     = c - z;
				r.out_c = clamp_q14(yq + C_R_CR * dcr + ROUND_HALF);
				r.out_b = clamp_q14(yq - C_G_CR * dcr - C_G_CB * dcb + ROUND_HALF);
				r.out_a = clamp_q14(yq + C_B_CB * dcb + ROUND_HALF);
			end
			MODE_BRIGHT_ALL: begin
				r.out_a = clamp8(a + k);
				r.out_b = clamp8(b + k);
				r.out_c = clamp8(c + k);
			end
			default: begin
				r.out_a = clamp8(a + k);
				r.out_b = p.chan_b;
				r.out_c = p.chan_c;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			chroma_zero <= CHROMA_OFFSET_RST;
			bright      <= BRIGHTNESS_OFFSET_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHROMA_OFFSET:     chroma_zero <= cfg_data[7:0];
					REG_BRIGHTNESS_OFFSET: bright      <= cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && pix_ready) begin
				expected_pix.push_back(convert_pixel(pix, chroma_zero, bright));
			end
			if (res_valid && res_ready) begin
				if (expected_pix.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result expected none got %0d %0d %0d",
						$time, res.out_a, res.out_b, res.out_c);
				end else begin
					want = expected_pix.pop_front();
					check_field("out_a", want.out_a, res.out_a);
					check_field("out_b", want.out_b, res.out_b);
					check_field("out_c", want.out_c, res.out_c);
				end
			end
			queued = expected_pix.size();
		end
	end

endmodule

/* bench/pixel_color_space_converter_test.sv */
`timescale 1ns / 100ps

module pixel_color_space_converter_test;
	import pcsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 250;

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_ready;
	pix_in_t              pix;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	pix_out_t             res;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 no_idle = 1'b0;
	int                   errors;
	int                   pending;
	int                   quiet_cycles = 0;

	pixel_color_space_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pixel_result_checker results (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		res_ready <= no_idle || ($urandom_range(0, 99) >= 37);
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic pix_in_t pixel_req(input mode_t m, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		pix_in_t p;
		p.mode   = m;
		p.chan_a = a;
		p.chan_b = b;
		p.chan_c = c;
		return p;
	endfunction

	// bias toward the rails so clamping shows up often
	function automatic logic [7:0] chan_val();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input pix_in_t p);
		while (!no_idle && $urandom_range(0, 99) < 37) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_random_config();
		logic [8:0] zero_val;
		logic [8:0] k_val;
		case ($urandom_range(0, 3))
			0:       zero_val = 9'h000;
			1:       zero_val = 9'h0FF;
			default: zero_val = 9'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0:       k_val = 9'h0FF;
			1:       k_val = 9'h100;
			2:       k_val = 9'h101;
			3:       k_val = 9'h000;
			default: k_val = 9'($urandom);
		endcase
		if ($urandom_range(0, 1)) begin
			write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 9'($urandom));
		end
		write_reg(REG_CHROMA_OFFSET, zero_val);
		write_reg(REG_BRIGHTNESS_OFFSET, k_val);
	endtask

	initial begin
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero level 128, no brightness
		send_pixel(pixel_req(MODE_TO_YCC, 8'd0, 8'd0, 8'd0));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd255, 8'd255, 8'd255));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd255, 8'd0, 8'd0));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd0, 8'd255, 8'd0));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd0, 8'd0, 8'd255));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd0, 8'd255, 8'd255));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd255, 8'd0, 8'd0));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd128, 8'd128, 8'd128));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd0, 8'd0, 8'd0));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd255, 8'd255, 8'd255));
		send_pixel(pixel_req(MODE_BRIGHT_ALL, 8'd200, 8'd10, 8'd255));
		send_pixel(pixel_req(MODE_BRIGHT_LUMA, 8'd255, 8'd0, 8'd128));

		drain_results();
		write_reg(REG_CHROMA_OFFSET, 9'h000);
		write_reg(REG_BRIGHTNESS_OFFSET, 9'h0FF);
		send_pixel(pixel_req(MODE_BRIGHT_ALL, 8'd0, 8'd1, 8'd255));
		send_pixel(pixel_req(MODE_BRIGHT_LUMA, 8'd1, 8'd255, 8'd0));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd0, 8'd255, 8'd0));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd10, 8'd20, 8'd30));

		// spare indexes must leave both registers alone; -256 brightness
		drain_results();
		write_reg(REG_SPARE_2, 9'h1FF);
		write_reg(REG_SPARE_3, 9'h1AA);
		write_reg(REG_CHROMA_OFFSET, 9'h1FF);
		write_reg(REG_BRIGHTNESS_OFFSET, 9'h100);
		send_pixel(pixel_req(MODE_BRIGHT_ALL, 8'd255, 8'd255, 8'd0));
		send_pixel(pixel_req(MODE_BRIGHT_LUMA, 8'd255, 8'd7, 8'd9));
		send_pixel(pixel_req(MODE_TO_BGR, 8'd255, 8'd0, 8'd0));
		send_pixel(pixel_req(MODE_TO_YCC, 8'd0, 8'd0, 8'd255));

		drain_results();
		write_reg(REG_BRIGHTNESS_OFFSET, 9'h101);
		send_pixel(pixel_req(MODE_BRIGHT_ALL, 8'd255, 8'd0, 8'd128));
		send_pixel(pixel_req(MODE_BRIGHT_LUMA, 8'd0, 8'd200, 8'd100));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			set_random_config();
			no_idle <= (ph == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_pixel(pixel_req(mode_t'($urandom_range(0, 3)),
					chan_val(), chan_val(), chan_val()));
			end
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* pixel_color_space_converter.f */
src/pcsc_pkg.sv
src/pcsc_datapath.sv
src/pixel_color_space_converter.sv
src/pcsc_checker.sv
bench/pixel_result_checker.sv
bench/pixel_color_space_converter_test.sv
